[sv/weighted_random_pick_sign_core_defines.svh]
// Assertion macros shared by the weighted random pick RTL.
`ifndef WEIGHTED_RANDOM_PICK_SIGN_CORE_DEFINES_SVH
`define WEIGHTED_RANDOM_PICK_SIGN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WRPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrps: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WRPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrps: next-cycle check failed");

`endif

[sv/wrps_pkg.sv]
// Constants and sign codes for the weighted random pick block.
`timescale 1ns / 1ps

package wrps_pkg;

    localparam int MAX_ELEMS   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 17;
    localparam int FRAC_SHIFT  = 16;

    localparam int IDX_BITS    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_ELEMS + 1);
    // running sum of magnitudes, each at most 2**(WEIGHT_BITS-1)
    localparam int CUM_BITS    = WEIGHT_BITS + IDX_BITS;
    localparam int PROD_BITS   = FRAC_BITS + CUM_BITS;
    localparam int SIGN_BITS   = 2;
    localparam int ENTRY_BITS  = CUM_BITS + SIGN_BITS;

    localparam logic signed [SIGN_BITS-1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [SIGN_BITS-1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [SIGN_BITS-1:0] SIGN_NEG  = 2'sb11;

endpackage

[sv/weighted_random_pick_sign_core.sv]
// Top level of the weighted random pick: load, product, threshold scan and emission.
`timescale 1ns / 1ps
`include "weighted_random_pick_sign_core_defines.svh"

// Weighted random pick over a signed weight vector. Each request carries one
// weight; its running magnitude sum and sign go into one RAM entry. The
// request marked last also carries the fraction. The block then forms the
// fraction-times-total product in S_MUL. It then scans the RAM one entry a
// cycle and stops at the first hit, or at the last entry held if none hits
// (at most MAX_ELEMS entries). Last, it emits one result per element held,
// one per cycle while out_ready stays high. No request is taken during the
// scan and emission. Weights beyond MAX_ELEMS are dropped. The RAM needs no
// clearing after reset.
module weighted_random_pick_sign_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [wrps_pkg::WEIGHT_BITS-1:0]  weight,
    input  logic [wrps_pkg::FRAC_BITS-1:0]           rand_fraction,
    input  logic                                     last,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [wrps_pkg::SIGN_BITS-1:0]    new_value,
    output logic [wrps_pkg::IDX_BITS-1:0]            chosen_index,
    output logic                                     end_of_run
);

    import wrps_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MUL,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CUM_BITS-1:0]    total_reg, total_next;

    logic [FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [IDX_BITS-1:0]    last_idx_reg, last_idx_next;
    logic [IDX_BITS-1:0]    chk_idx_reg, chk_idx_next;
    logic [IDX_BITS-1:0]    emit_idx_reg, emit_idx_next;
    logic [IDX_BITS-1:0]    pick_reg, pick_next;
    logic [SIGN_BITS-1:0]   pick_sign_reg, pick_sign_next;

    logic                   in_fire;
    logic                   out_fire;
    logic                   has_room;
    logic                   neg;
    logic [WEIGHT_BITS-1:0] mag;
    logic [SIGN_BITS-1:0]   elem_sign;
    logic [CUM_BITS-1:0]    sum_inc;
    logic [CNT_BITS-1:0]    count_inc;

    logic                   ram_we;
    logic [IDX_BITS-1:0]    ram_waddr;
    logic [ENTRY_BITS-1:0]  ram_wdata;
    logic [IDX_BITS-1:0]    ram_raddr;
    logic [ENTRY_BITS-1:0]  ram_rdata;

    logic [CUM_BITS-1:0]    rd_cum;
    logic [SIGN_BITS-1:0]   rd_sign;
    logic [PROD_BITS-1:0]   rd_scaled;
    logic                   hit;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // magnitude of the most negative weight still fits unsigned in WEIGHT_BITS
    assign neg       = weight[WEIGHT_BITS-1];
    assign mag       = neg ? (~weight + 1'b1) : weight;
    assign elem_sign = neg ? SIGN_NEG : ((weight != '0) ? SIGN_POS : SIGN_ZERO);
    assign has_room  = (count_reg < CNT_BITS'(MAX_ELEMS));
    assign sum_inc   = total_reg + CUM_BITS'(mag);
    assign count_inc = count_reg + 1'b1;

    assign ram_we    = in_fire && has_room;
    assign ram_waddr = count_reg[IDX_BITS-1:0];
    assign ram_wdata = {elem_sign, sum_inc};
    assign ram_raddr = (state_reg == S_SCAN) ? (chk_idx_reg + 1'b1) : '0;

    assign rd_cum    = ram_rdata[CUM_BITS-1:0];
    assign rd_sign   = ram_rdata[ENTRY_BITS-1:CUM_BITS];
    // cumulative * 65536 > fraction * total, no division
    assign rd_scaled = {{(PROD_BITS-CUM_BITS-FRAC_SHIFT){1'b0}}, rd_cum, {FRAC_SHIFT{1'b0}}};
    assign hit       = (rd_scaled > prod_reg);

    wrps_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        last_idx_next  = last_idx_reg;
        chk_idx_next   = chk_idx_reg;
        emit_idx_next  = emit_idx_reg;
        pick_next      = pick_reg;
        pick_sign_next = pick_sign_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        total_next    = sum_inc;
                        count_next    = count_inc;
                        last_idx_next = count_reg[IDX_BITS-1:0];
                    end
                    else
                    begin
                        last_idx_next = IDX_BITS'(MAX_ELEMS - 1);
                    end
                    if (last)
                    begin
                        frac_next  = rand_fraction;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // RAM entry 0 is being read this cycle
                prod_next    = PROD_BITS'(frac_reg) * PROD_BITS'(total_reg);
                chk_idx_next = '0;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit || (chk_idx_reg == last_idx_reg))
                begin
                    pick_next      = chk_idx_reg;
                    pick_sign_next = rd_sign;
                    emit_idx_next  = '0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    if (emit_idx_reg == last_idx_reg)
                    begin
                        total_next = '0;
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg      <= frac_next;
        prod_reg      <= prod_next;
        last_idx_reg  <= last_idx_next;
        chk_idx_reg   <= chk_idx_next;
        emit_idx_reg  <= emit_idx_next;
        pick_reg      <= pick_next;
        pick_sign_reg <= pick_sign_next;
    end

    assign new_value    = (emit_idx_reg == pick_reg) ? pick_sign_reg : SIGN_ZERO;
    assign chosen_index = pick_reg;
    assign end_of_run   = (emit_idx_reg == last_idx_reg);

    `WRPS_ASSERT_NOW(a_no_load_while_emit, in_ready, !out_valid)
    `WRPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(MAX_ELEMS))
    `WRPS_ASSERT_NEXT(a_clear_after_run, out_fire && end_of_run, (count_reg == '0) && (total_reg == '0) && in_ready)
    `WRPS_ASSERT_NOW(a_emit_not_past_end, out_valid, emit_idx_reg <= last_idx_reg)

endmodule

[sv/wrps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module wrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/sv/tb_weighted_random_pick_sign_core.sv]
// Testbench for weighted_random_pick_sign_core: predicted picks vs. emitted results.
`timescale 1ns / 1ps

module tb_weighted_random_pick_sign_core;

    import wrps_pkg::*;

    localparam int TOTAL_ITEMS = 170;
    localparam int CALM_ITEMS  = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(1 << FRAC_SHIFT);

    // Tracks the loaded vector and the per-element results each pick must produce.
    class wheel_pick_checker;
        typedef struct packed {
            logic signed [SIGN_BITS-1:0] sign_out;
            logic [IDX_BITS-1:0]         index;
            logic                        run_end;
        } pick_result_t;

        longint unsigned             cum_sum[MAX_ELEMS];
        logic signed [SIGN_BITS-1:0] elem_sign[MAX_ELEMS];
        longint unsigned             total;
        int                          count;
        pick_result_t                expected_picks[$];
        int                          errors;

        function new();
            total  = 0;
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        function void note_weight(logic signed [WEIGHT_BITS-1:0] w,
                                  logic [FRAC_BITS-1:0] frac, logic is_last);
            int              wi;
            int              i;
            int              pick;
            longint unsigned mag;
            longint unsigned threshold;
            pick_result_t    r;

            wi  = w;
            mag = (wi < 0) ? longint'(-wi) : longint'(wi);
            // weights past a full vector are dropped, total included
            if (count < MAX_ELEMS)
            begin
                total            = total + mag;
                cum_sum[count]   = total;
                elem_sign[count] = (wi < 0) ? SIGN_NEG : ((wi != 0) ? SIGN_POS : SIGN_ZERO);
                count++;
            end
            if (!is_last)
                return;

            // cum * 2^16 > frac * total; falls back to the last element
            threshold = longint'(frac) * total;
            pick      = count - 1;
            for (i = 0; i < count; i++)
            begin
                if ((cum_sum[i] << FRAC_SHIFT) > threshold)
                begin
                    pick = i;
                    break;
                end
            end

            for (i = 0; i < count; i++)
            begin
                r.sign_out = (i == pick) ? elem_sign[i] : SIGN_ZERO;
                r.index    = pick[IDX_BITS-1:0];
                r.run_end  = (i == count - 1);
                expected_picks.insert(expected_picks.size(), r);
            end
            total = 0;
            count = 0;
        endfunction

        function void check_output(logic signed [SIGN_BITS-1:0] sign_out,
                                   logic [IDX_BITS-1:0] index, logic run_end);
            pick_result_t exp_r;

            if (expected_picks.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result new_value=%0d chosen_index=%0d end_of_run=%0b",
                             $realtime, sign_out, index, run_end);
                return;
            end
            exp_r = expected_picks.pop_front();
            if (sign_out !== exp_r.sign_out || index !== exp_r.index
                || run_end !== exp_r.run_end)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch expected (%0d, %0d, %0b) got (%0d, %0d, %0b)",
                             $realtime, exp_r.sign_out, exp_r.index, exp_r.run_end,
                             sign_out, index, run_end);
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic signed [WEIGHT_BITS-1:0]  weight;
    logic [FRAC_BITS-1:0]           rand_fraction;
    logic                           last;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [SIGN_BITS-1:0]    new_value;
    logic [IDX_BITS-1:0]            chosen_index;
    logic                           end_of_run;

    wheel_pick_checker              sb;
    logic signed [WEIGHT_BITS-1:0]  vec_weights[$];
    int                             items_sent = 0;
    int                             stall_cycles = 0;
    bit                             calm = 1'b0;
    bit                             hold_output = 1'b0;
    bit                             hold_done = 1'b0;

    weighted_random_pick_sign_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .weight       (weight),
        .rand_fraction(rand_fraction),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_value    (new_value),
        .chosen_index (chosen_index),
        .end_of_run   (end_of_run)
    );

    always #1 clk = ~clk;

    function automatic logic signed [WEIGHT_BITS-1:0] pick_weight();
        int mag;

        mag = $urandom_range(0, 20);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WEIGHT_MIN;
            2:       return WEIGHT_MAX;
            3, 4:    return ($urandom_range(0, 1) == 1) ? WEIGHT_BITS'(-mag) : WEIGHT_BITS'(mag);
            default: return WEIGHT_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FRAC_ONE;
            2:       return FRAC_BITS'($urandom_range(FRAC_ONE + 1, (1 << FRAC_BITS) - 1));
            3:       return FRAC_BITS'(FRAC_ONE - 1);
            default: return FRAC_BITS'($urandom_range(0, FRAC_ONE - 1));
        endcase
    endfunction

    task automatic send_request(input logic signed [WEIGHT_BITS-1:0] w,
                                input logic [FRAC_BITS-1:0] frac, input logic is_last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        weight        <= w;
        rand_fraction <= frac;
        last          <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_weight(w, frac, is_last);
        items_sent++;
    endtask

    // fraction only matters on the last request; the others carry noise
    task automatic send_vector(input logic [FRAC_BITS-1:0] frac);
        int i;

        for (i = 0; i < vec_weights.size(); i++)
        begin
            if (i == vec_weights.size() - 1)
                send_request(vec_weights[i], frac, 1'b1);
            else
                send_request(vec_weights[i], FRAC_BITS'($urandom()), 1'b0);
        end
    endtask

    initial
    begin
        int vec_count;
        int len;
        bit all_zero;

        sb = new();
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        weight        <= '0;
        rand_fraction <= '0;
        last          <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single zero weight: zero total
        vec_weights = '{16'sd0};
        send_vector('0);
        // fraction of one
        vec_weights = '{WEIGHT_MAX, WEIGHT_MIN, 16'sd1};
        send_vector(FRAC_ONE);
        vec_weights = '{WEIGHT_MIN, WEIGHT_MAX};
        send_vector('0);
        vec_weights = '{16'sd0, 16'sd0, 16'sd5};
        send_vector('1);
        vec_weights = '{16'sd3, -16'sd4, 16'sd0, 16'sd7};
        send_vector(FRAC_ONE >> 1);
        vec_weights = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        send_vector(17'd1);
        vec_weights = '{-16'sd1, -16'sd2, 16'sd4};
        send_vector(17'd21845);
        vec_weights = '{16'sd5, -16'sd5};
        send_vector(FRAC_ONE - 1);

        // output blocked for a while so the block backs up into its input
        hold_output = 1'b1;
        vec_count = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (vec_count == 1)
                len = MAX_ELEMS + 2;  // overflow: extra weights dropped
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(9, 20);
            else
                len = $urandom_range(1, 8);
            all_zero = ($urandom_range(0, 11) == 0);
            vec_weights.delete();
            repeat (len)
                vec_weights.insert(vec_weights.size(), all_zero ? '0 : pick_weight());
            send_vector(pick_fraction());
            vec_count++;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && out_ready)
            sb.check_output(new_value, chosen_index, end_of_run);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

[files.f]
+incdir+sv
sv/wrps_pkg.sv
sv/wrps_ram.sv
sv/weighted_random_pick_sign_core.sv
tb/sv/tb_weighted_random_pick_sign_core.sv
